### sv/mbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monochrome bitmap raster engine package
// Shared item types, command codes and sequencer states for the raster engine.
// ----------------------------------------------------------------------------
package mbr_pkg;

    // Field widths fixed by the item formats.
    localparam int CMD_W    = 3;
    localparam int COORD_W  = 6;
    localparam int SIZE_W   = 7;
    localparam int FACTOR_W = 8;
    localparam int AREA_W   = 13;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        OP_WRITE     = 3'd0,
        OP_SET_SIZE  = 3'd1,
        OP_OR_PIXEL  = 3'd2,
        OP_SUB_PIXEL = 3'd3,
        OP_INVERT    = 3'd4,
        OP_CLEAR     = 3'd5,
        OP_SCALE     = 3'd6,
        OP_READ      = 3'd7
    } mbr_op_t;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_RUN,
        ST_WALK,
        ST_DIV,
        ST_SROW,
        ST_SWAIT,
        ST_SCOL,
        ST_SWR,
        ST_DONE
    } mbr_state_t;

    // Command item as presented on the input side.
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic                pixel_value;
        logic [SIZE_W-1:0]   new_height;
        logic [SIZE_W-1:0]   new_width;
        logic [FACTOR_W-1:0] scale_factor;
    } mbr_in_t;

    // Result item as presented on the output side.
    typedef struct packed {
        logic                pixel_out;
        logic [SIZE_W-1:0]   current_height;
        logic [SIZE_W-1:0]   current_width;
        logic [AREA_W-1:0]   pixel_area;
        logic                size_clipped;
        logic                coord_error;
    } mbr_out_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        mbr_op_t             op;
        logic                is_long;
        logic                in_store;
        logic                h_clip;
        logic                w_clip;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic                pixel_value;
        logic [SIZE_W-1:0]   new_height;
        logic [SIZE_W-1:0]   new_width;
        logic [FACTOR_W-1:0] scale_factor;
    } mbr_job_t;

endpackage

### sv/mbr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; a read of the address being written returns old data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/mbr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small queue
// Register-based first-in first-out queue with full, almost full and empty.
// ----------------------------------------------------------------------------
module mbr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    output logic             afull,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign afull   = (count_reg >= CNTW'(DEPTH - 1));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        count_next = count_reg + CNTW'(do_push) - CNTW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

### sv/mbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster engine front end
// Accepts command items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module mbr_front #(
    parameter int MAX_SIZE = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbr_pkg::mbr_in_t  cmd,
    output logic              full,
    input  logic              hold,
    input  logic              job_take,
    output logic              job_valid,
    output mbr_pkg::mbr_job_t job
);

    import mbr_pkg::*;

    localparam int CW = ($clog2(MAX_SIZE + 1) > SIZE_W) ? $clog2(MAX_SIZE + 1) : SIZE_W;

    mbr_job_t class_job;
    logic     q_full;
    logic     q_empty;

    // Classify the incoming item: decode, storage range and size saturation.
    always_comb
    begin
        class_job.op           = mbr_op_t'(cmd.command);
        class_job.is_long      = (class_job.op == OP_INVERT) || (class_job.op == OP_CLEAR) ||
                                 (class_job.op == OP_SCALE);
        class_job.in_store     = (CW'(cmd.row) < CW'(MAX_SIZE)) &&
                                 (CW'(cmd.col) < CW'(MAX_SIZE));
        class_job.h_clip       = (CW'(cmd.new_height) > CW'(MAX_SIZE));
        class_job.w_clip       = (CW'(cmd.new_width) > CW'(MAX_SIZE));
        class_job.row          = cmd.row;
        class_job.col          = cmd.col;
        class_job.pixel_value  = cmd.pixel_value;
        class_job.new_height   = cmd.new_height;
        class_job.new_width    = cmd.new_width;
        class_job.scale_factor = cmd.scale_factor;
    end

    // The input side reports full while the queue is full or the frame is being zeroed after reset.
    assign full      = q_full || hold;
    assign job_valid = !q_empty;

    mbr_fifo #(
        .WIDTH ($bits(mbr_job_t)),
        .DEPTH (2)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .din   (class_job),
        .full  (q_full),
        .afull (),
        .pop   (job_take),
        .dout  (job),
        .empty (q_empty)
    );

endmodule

### sv/mbr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster engine back end
// Executes classified commands on the row-wide frame memory and queues results.
// ----------------------------------------------------------------------------
module mbr_back #(
    parameter int MAX_SIZE         = 64,
    parameter int FACTOR_FRAC_BITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  mbr_pkg::mbr_job_t job,
    output logic              job_take,
    output logic              hold,
    input  logic              pop,
    output logic              empty,
    output mbr_pkg::mbr_out_t result
);

    import mbr_pkg::*;

    localparam int AW  = $clog2(MAX_SIZE);
    localparam int DW  = $clog2(MAX_SIZE + 1);
    localparam int CW  = (DW > SIZE_W) ? DW : SIZE_W;
    localparam int NW  = AW + FACTOR_FRAC_BITS;
    localparam int QW  = FACTOR_FRAC_BITS + 1;
    localparam int DCW = $clog2(FACTOR_FRAC_BITS + 2);
    localparam int PW  = DW + FACTOR_W;

    // One incremental step of a quotient and remainder by a fixed increment.
    function automatic logic [NW+7:0] div_step(
        input logic [NW-1:0]       q,
        input logic [7:0]          r,
        input logic [QW-1:0]       inc_q,
        input logic [7:0]          inc_r,
        input logic [FACTOR_W-1:0] d
    );
        logic [8:0]    rs;
        logic          ge;
        logic [NW-1:0] qn;
        logic [7:0]    rn;
        rs = {1'b0, r} + {1'b0, inc_r};
        ge = (rs >= {1'b0, d});
        rn = ge ? 8'(rs - {1'b0, d}) : rs[7:0];
        qn = q + NW'(inc_q) + NW'(ge);
        return {qn, rn};
    endfunction

    // Control state.
    mbr_state_t          state_reg, state_next;
    logic                b_valid_reg, b_valid_next;
    logic                byp_valid_reg, byp_valid_next;
    logic                p_valid_reg, p_valid_next;
    logic [DW-1:0]       h_reg, h_next;
    logic [DW-1:0]       w_reg, w_next;
    logic [DW-1:0]       k_reg, k_next;

    // Payload state.
    mbr_job_t            b_job_reg, b_job_next;
    logic [AW-1:0]       byp_row_reg, byp_row_next;
    logic [MAX_SIZE-1:0] byp_data_reg, byp_data_next;
    logic [AW-1:0]       p_row_reg, p_row_next;
    mbr_op_t             op_reg, op_next;
    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic [DW-1:0]       nh_reg, nh_next;
    logic [DW-1:0]       nw_reg, nw_next;
    logic                clip_reg, clip_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [7:0]          rem_reg, rem_next;
    logic [DCW-1:0]      div_cnt_reg, div_cnt_next;
    logic [DW-1:0]       i_reg, i_next;
    logic [NW-1:0]       qi_reg, qi_next;
    logic [7:0]          ri_reg, ri_next;
    logic                src_ok_reg, src_ok_next;
    logic [DW-1:0]       j_reg, j_next;
    logic [NW-1:0]       qj_reg, qj_next;
    logic [7:0]          rj_reg, rj_next;
    logic [MAX_SIZE-1:0] src_row_reg, src_row_next;
    logic [MAX_SIZE-1:0] dst_row_reg, dst_row_next;

    // Memory ports.
    logic                frame_we, copy_we;
    logic [AW-1:0]       frame_waddr, frame_raddr, copy_waddr, copy_raddr;
    logic [MAX_SIZE-1:0] frame_wdata, frame_rdata, copy_wdata, copy_rdata;

    // Pixel stage results.
    logic [AW-1:0]       b_addr, b_ci;
    logic [MAX_SIZE-1:0] b_row_data, b_new_row;
    logic                b_in_image, b_we, b_pix, b_cerr, b_clip;
    logic [DW-1:0]       b_h_new, b_w_new;

    // Result assembly.
    logic                res_push, res_full, res_afull, space_ok;
    logic                res_pix, res_clip, res_cerr;
    logic [DW-1:0]       res_h, res_w;
    logic [2*DW-1:0]     res_area;
    mbr_out_t            res_item;

    // Scale helpers.
    logic [PW-1:0]       prod_h, prod_w, sc_h, sc_w;
    logic                sc_h_clip, sc_w_clip;
    logic [MAX_SIZE-1:0] width_mask;
    logic [8:0]          rem_shift;
    logic                div_ge;
    logic [NW+7:0]       step_i, step_j;
    logic                qj_ok;

    // Pixel stage: read-modify-write of one row, with a bypass of the last row written.
    always_comb
    begin
        b_addr     = AW'(b_job_reg.row);
        b_ci       = AW'(b_job_reg.col);
        b_row_data = (byp_valid_reg && (byp_row_reg == b_addr)) ? byp_data_reg : frame_rdata;
        b_in_image = b_job_reg.in_store && (CW'(b_job_reg.row) < CW'(h_reg)) &&
                     (CW'(b_job_reg.col) < CW'(w_reg));
        b_new_row  = b_row_data;
        b_we       = 1'b0;
        b_pix      = 1'b0;
        b_cerr     = 1'b0;
        b_clip     = 1'b0;
        b_h_new    = h_reg;
        b_w_new    = w_reg;
        case (b_job_reg.op)
            OP_WRITE:
            begin
                b_cerr            = !b_in_image;
                b_we              = b_job_reg.in_store;
                b_new_row[b_ci]   = b_job_reg.pixel_value;
            end
            OP_SET_SIZE:
            begin
                b_h_new = b_job_reg.h_clip ? DW'(MAX_SIZE) : DW'(b_job_reg.new_height);
                b_w_new = b_job_reg.w_clip ? DW'(MAX_SIZE) : DW'(b_job_reg.new_width);
                b_clip  = b_job_reg.h_clip || b_job_reg.w_clip;
            end
            OP_OR_PIXEL:
            begin
                b_cerr          = !b_in_image;
                b_we            = b_in_image;
                b_new_row[b_ci] = b_row_data[b_ci] | b_job_reg.pixel_value;
            end
            OP_SUB_PIXEL:
            begin
                b_cerr          = !b_in_image;
                b_we            = b_in_image;
                b_new_row[b_ci] = b_row_data[b_ci] & ~b_job_reg.pixel_value;
            end
            OP_READ:
            begin
                b_cerr = !b_in_image;
                b_pix  = b_job_reg.in_store & b_row_data[b_ci];
            end
            default:
            begin
                b_we = 1'b0;
            end
        endcase
        b_we = b_we && b_valid_reg;
    end

    // Columns inside the current width.
    always_comb
    begin
        for (int j = 0; j < MAX_SIZE; j++)
        begin
            width_mask[j] = (j < int'(w_reg));
        end
    end

    // Scaled size of the image, from the head command's factor.
    always_comb
    begin
        prod_h    = PW'(h_reg) * PW'(job.scale_factor);
        prod_w    = PW'(w_reg) * PW'(job.scale_factor);
        sc_h      = prod_h >> FACTOR_FRAC_BITS;
        sc_w      = prod_w >> FACTOR_FRAC_BITS;
        sc_h_clip = (sc_h > PW'(MAX_SIZE));
        sc_w_clip = (sc_w > PW'(MAX_SIZE));
    end

    // Reciprocal step: one quotient bit of 2^F / factor per cycle, and the source walks.
    always_comb
    begin
        rem_shift = {rem_reg, (div_cnt_reg == '0)};
        div_ge    = (rem_shift >= {1'b0, factor_reg});
        step_i    = div_step(qi_reg, ri_reg, quo_reg, rem_reg, factor_reg);
        step_j    = div_step(qj_reg, rj_reg, quo_reg, rem_reg, factor_reg);
        qj_ok     = ({1'b0, qj_reg} < (NW + 1)'(MAX_SIZE));
    end

    assign space_ok = b_valid_reg ? !res_afull : !res_full;
    assign hold     = (state_reg == ST_INIT);

    // Sequencer: next state, memory control and counters.
    always_comb
    begin
        state_next     = state_reg;
        b_valid_next   = 1'b0;
        b_job_next     = b_job_reg;
        byp_valid_next = b_we;
        byp_row_next   = b_addr;
        byp_data_next  = b_new_row;
        p_valid_next   = 1'b0;
        p_row_next     = p_row_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        k_next         = k_reg;
        op_next        = op_reg;
        factor_next    = factor_reg;
        nh_next        = nh_reg;
        nw_next        = nw_reg;
        clip_next      = clip_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        i_next         = i_reg;
        qi_next        = qi_reg;
        ri_next        = ri_reg;
        src_ok_next    = src_ok_reg;
        j_next         = j_reg;
        qj_next        = qj_reg;
        rj_next        = rj_reg;
        src_row_next   = src_row_reg;
        dst_row_next   = dst_row_reg;
        frame_we       = 1'b0;
        frame_waddr    = p_row_reg;
        frame_wdata    = frame_rdata;
        frame_raddr    = AW'(k_reg);
        copy_we        = 1'b0;
        copy_waddr     = p_row_reg;
        copy_wdata     = frame_rdata;
        copy_raddr     = AW'(qi_reg);
        job_take       = 1'b0;
        res_push       = 1'b0;
        res_pix        = b_pix;
        res_h          = b_h_new;
        res_w          = b_w_new;
        res_clip       = b_clip;
        res_cerr       = b_cerr;

        case (state_reg)
            // Zero every row of the frame after reset.
            ST_INIT:
            begin
                frame_we    = 1'b1;
                frame_waddr = AW'(k_reg);
                frame_wdata = '0;
                k_next      = k_reg + DW'(1);
                if (k_reg == DW'(MAX_SIZE - 1))
                begin
                    state_next = ST_RUN;
                end
            end

            // Pixel commands flow through a two-stage read-modify-write pipeline.
            ST_RUN:
            begin
                if (b_valid_reg)
                begin
                    frame_we    = b_we;
                    frame_waddr = b_addr;
                    frame_wdata = b_new_row;
                    res_push    = 1'b1;
                    h_next      = b_h_new;
                    w_next      = b_w_new;
                end
                if (job_valid && !job.is_long && space_ok)
                begin
                    job_take     = 1'b1;
                    b_valid_next = 1'b1;
                    b_job_next   = job;
                    frame_raddr  = AW'(job.row);
                end
                else if (job_valid && job.is_long && !b_valid_reg)
                begin
                    job_take    = 1'b1;
                    op_next     = job.op;
                    factor_next = job.scale_factor;
                    nh_next     = sc_h_clip ? DW'(MAX_SIZE) : DW'(sc_h);
                    nw_next     = sc_w_clip ? DW'(MAX_SIZE) : DW'(sc_w);
                    clip_next   = sc_h_clip || sc_w_clip;
                    k_next      = '0;
                    state_next  = ST_WALK;
                end
            end

            // Row walk over the image: invert, clear, or copy to scratch before scaling.
            ST_WALK:
            begin
                if (k_reg < h_reg)
                begin
                    k_next       = k_reg + DW'(1);
                    p_valid_next = 1'b1;
                    p_row_next   = AW'(k_reg);
                end
                if (p_valid_reg)
                begin
                    case (op_reg)
                        OP_INVERT:
                        begin
                            frame_we    = 1'b1;
                            frame_wdata = frame_rdata ^ width_mask;
                        end
                        OP_CLEAR:
                        begin
                            frame_we    = 1'b1;
                            frame_wdata = frame_rdata & ~width_mask;
                        end
                        OP_SCALE:
                        begin
                            copy_we = 1'b1;
                        end
                        default:
                        begin
                            frame_we = 1'b0;
                        end
                    endcase
                end
                if (!(k_reg < h_reg) && !p_valid_reg)
                begin
                    quo_next     = '0;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = (op_reg == OP_SCALE) ? ST_DIV : ST_DONE;
                end
            end

            // Restoring division of 2^F by the factor.
            ST_DIV:
            begin
                rem_next     = div_ge ? 8'(rem_shift - {1'b0, factor_reg}) : rem_shift[7:0];
                quo_next     = (quo_reg << 1) | QW'(div_ge);
                div_cnt_next = div_cnt_reg + DCW'(1);
                i_next       = '0;
                qi_next      = '0;
                ri_next      = '0;
                if (div_cnt_reg == DCW'(FACTOR_FRAC_BITS))
                begin
                    state_next = (nh_reg != '0) ? ST_SROW : ST_DONE;
                end
            end

            // Fetch the source row from scratch and the destination row from the frame.
            ST_SROW:
            begin
                copy_raddr  = AW'(qi_reg);
                frame_raddr = AW'(i_reg);
                src_ok_next = ({1'b0, qi_reg} < (NW + 1)'(MAX_SIZE));
                state_next  = ST_SWAIT;
            end

            ST_SWAIT:
            begin
                src_row_next = copy_rdata;
                dst_row_next = frame_rdata;
                j_next       = '0;
                qj_next      = '0;
                rj_next      = '0;
                state_next   = ST_SCOL;
            end

            // One destination column per cycle inside the new width.
            ST_SCOL:
            begin
                if (j_reg < nw_reg)
                begin
                    dst_row_next[AW'(j_reg)] = (src_ok_reg && qj_ok) ?
                                               src_row_reg[AW'(qj_reg)] : 1'b0;
                    j_next  = j_reg + DW'(1);
                    qj_next = step_j[NW+7:8];
                    rj_next = step_j[7:0];
                end
                else
                begin
                    state_next = ST_SWR;
                end
            end

            ST_SWR:
            begin
                frame_we    = 1'b1;
                frame_waddr = AW'(i_reg);
                frame_wdata = dst_row_reg;
                i_next      = i_reg + DW'(1);
                qi_next     = step_i[NW+7:8];
                ri_next     = step_i[7:0];
                state_next  = ((i_reg + DW'(1)) < nh_reg) ? ST_SROW : ST_DONE;
            end

            // Report a frame command once the result queue has room.
            ST_DONE:
            begin
                res_pix  = 1'b0;
                res_cerr = 1'b0;
                res_h    = (op_reg == OP_SCALE) ? nh_reg : h_reg;
                res_w    = (op_reg == OP_SCALE) ? nw_reg : w_reg;
                res_clip = (op_reg == OP_SCALE) && clip_reg;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    h_next     = res_h;
                    w_next     = res_w;
                    state_next = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Result item.
    always_comb
    begin
        res_area                = (2 * DW)'(res_h) * (2 * DW)'(res_w);
        res_item.pixel_out      = res_pix;
        res_item.current_height = SIZE_W'(res_h);
        res_item.current_width  = SIZE_W'(res_w);
        res_item.pixel_area     = AREA_W'(res_area);
        res_item.size_clipped   = res_clip;
        res_item.coord_error    = res_cerr;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            b_valid_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
            p_valid_reg   <= 1'b0;
            h_reg         <= '0;
            w_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            b_valid_reg   <= b_valid_next;
            byp_valid_reg <= byp_valid_next;
            p_valid_reg   <= p_valid_next;
            h_reg         <= h_next;
            w_reg         <= w_next;
            k_reg         <= k_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        b_job_reg    <= b_job_next;
        byp_row_reg  <= byp_row_next;
        byp_data_reg <= byp_data_next;
        p_row_reg    <= p_row_next;
        op_reg       <= op_next;
        factor_reg   <= factor_next;
        nh_reg       <= nh_next;
        nw_reg       <= nw_next;
        clip_reg     <= clip_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        i_reg        <= i_next;
        qi_reg       <= qi_next;
        ri_reg       <= ri_next;
        src_ok_reg   <= src_ok_next;
        j_reg        <= j_next;
        qj_reg       <= qj_next;
        rj_reg       <= rj_next;
        src_row_reg  <= src_row_next;
        dst_row_reg  <= dst_row_next;
    end

    // Frame memory: one image row per word.
    mbr_ram #(
        .WIDTH (MAX_SIZE),
        .DEPTH (MAX_SIZE)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    // Scratch copy of the frame used while scaling.
    mbr_ram #(
        .WIDTH (MAX_SIZE),
        .DEPTH (MAX_SIZE)
    ) u_copy_ram (
        .clk   (clk),
        .we    (copy_we),
        .waddr (copy_waddr),
        .wdata (copy_wdata),
        .raddr (copy_raddr),
        .rdata (copy_rdata)
    );

    // Result queue towards the output side.
    mbr_fifo #(
        .WIDTH ($bits(mbr_out_t)),
        .DEPTH (4)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_item),
        .full  (res_full),
        .afull (res_afull),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule

### sv/mono_bitmap_raster_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monochrome bitmap raster engine
// One-bit image store with pixel edits, whole-image edits and scaling.
// ----------------------------------------------------------------------------
// The image is held one row per word in a single-port-write frame memory of
// MAX_SIZE rows. Write, OR, subtract, read and set-size items pass through a
// two-stage read-modify-write pipeline and sustain one item per cycle while the
// result queue has room. Invert and clear walk the image one row per memory
// access. Scale copies the old rows to a scratch memory, runs a reciprocal
// step, then rebuilds each new row one column per cycle. After reset a
// clearing pass zeroes every row of the frame, and full stays high until it
// ends.
module mono_bitmap_raster_engine #(
    parameter int MAX_SIZE         = 64,
    parameter int FACTOR_FRAC_BITS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  mbr_pkg::mbr_in_t cmd,
    output logic             empty,
    input  logic             pop,
    output mbr_pkg::mbr_out_t result
);

    import mbr_pkg::*;

    mbr_job_t job;
    logic     job_valid;
    logic     job_take;
    logic     hold;

    // Front end: accept and classify items.
    mbr_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd       (cmd),
        .full      (full),
        .hold      (hold),
        .job_take  (job_take),
        .job_valid (job_valid),
        .job       (job)
    );

    // Back end: execute on the frame and queue results.
    mbr_back #(
        .MAX_SIZE         (MAX_SIZE),
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .hold      (hold),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
